// ----- hw/rtl/ppoc_pkg.sv -----
// Shared types and constants for the pin power output controller.
`default_nettype none

package ppoc_pkg;

  localparam int PIN_COUNT_DEF    = 64;
  localparam int ANALOG_FIRST_DEF = 54;
  localparam int PIN_W            = 6;
  localparam int ACT_W            = 4;
  localparam int POWER_W          = 8;
  localparam int MASK_W           = 64;

  localparam logic [MASK_W-1:0]  PWM_MASK_RESET = 64'h0000_7000_0000_3FFC;
  localparam logic [POWER_W-1:0] POWER_MAX      = 8'hFF;

  typedef enum logic [ACT_W-1:0] {
    ACT_SELECT    = 4'd0,
    ACT_SET_POWER = 4'd1,
    ACT_ON        = 4'd2,
    ACT_OFF       = 4'd3,
    ACT_LEFT      = 4'd4,
    ACT_RIGHT     = 4'd5,
    ACT_PULL_UP   = 4'd6,
    ACT_PULL_NONE = 4'd7,
    ACT_READ      = 4'd8,
    ACT_STOP_ALL  = 4'd9
  } action_t;

  typedef struct packed {
    logic [POWER_W-1:0] power;
    logic               pull;
    logic               dir;
    logic               port;
    logic               pwm;
  } pin_rec_t;

endpackage

`default_nettype wire

// ----- hw/rtl/pin_power_output_controller_unit.sv -----
// Top level of the pin power output controller: pin record memory and command sequencer.
//
// Usage:
//   Commands enter on the in_ channel (valid/ready). Each transaction reports the
//   drive state of one or more pins on the out_ channel; out_last marks the final
//   report of a command. Ignored commands (unknown action, pin out of range, stop
//   all with no pin on) produce no report.
//   The cfg_ channel writes the PWM-capable pin mask; write it only while idle.
//   Per-pin power byte, pull, direction, port and PWM flags live in a 1-port-read,
//   1-port-write memory with registered read data; on flags are kept in flops.
//   A single-report command is taken in S_IDLE, which issues the read of its
//   record; in S_MOD the record is modified and written back, and the report is
//   valid the cycle after that. A new command is taken only in S_IDLE, once the
//   previous one has been written back. Select handles two records in turn
//   (S_MOD, S_ISSUE, S_MOD). Stop all scans pins in order, reading and writing
//   back each pin that is on, and ends as soon as no pin is left on.
//   The read of an entry is always issued after the previous write completes.
//   Reset (synchronous, rst_n low) clears all valid bits, so every pin reads as
//   power 255, off, pull set below the analog range, input, port 0, PWM off.
//   A stalled receiver holds the report register; the sequencer waits in its
//   write-back step until the report register is free.
`default_nettype none

module pin_power_output_controller_unit #(
  parameter int PIN_COUNT    = ppoc_pkg::PIN_COUNT_DEF,
  parameter int ANALOG_FIRST = ppoc_pkg::ANALOG_FIRST_DEF
) (
  input  wire                           clk,
  input  wire                           rst_n,

  input  wire                           in_valid,
  output logic                          in_ready,
  input  wire [ppoc_pkg::ACT_W-1:0]     in_action,
  input  wire [ppoc_pkg::PIN_W-1:0]     in_pin,
  input  wire [ppoc_pkg::PIN_W-1:0]     in_second_pin,
  input  wire [ppoc_pkg::POWER_W-1:0]   in_power_level,
  input  wire                           in_pin_in_level,

  input  wire                           cfg_valid,
  output logic                          cfg_ready,
  input  wire [ppoc_pkg::MASK_W-1:0]    cfg_pwm_capable_mask,

  output logic                          out_valid,
  input  wire                           out_ready,
  output logic [ppoc_pkg::PIN_W-1:0]    out_pin,
  output logic                          out_dir_output,
  output logic                          out_port_level,
  output logic                          out_pwm_enable,
  output logic [ppoc_pkg::POWER_W-1:0]  out_duty,
  output logic                          out_read_value,
  output logic                          out_is_analog,
  output logic                          out_last
);

  localparam int IDX_W = (PIN_COUNT > 1) ? $clog2(PIN_COUNT) : 1;
  localparam int CMP_W = ppoc_pkg::PIN_W + 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MOD,
    S_ISSUE,
    S_SCAN
  } state_t;

  state_t                          state_r, state_nxt;
  ppoc_pkg::action_t               act_r, act_nxt, in_act;
  logic [ppoc_pkg::PIN_W-1:0]      cur_pin_r, cur_pin_nxt;
  logic [ppoc_pkg::PIN_W-1:0]      sec_r, sec_nxt;
  logic [ppoc_pkg::PIN_W-1:0]      power_sel_r, power_sel_nxt;
  logic [ppoc_pkg::PIN_W-1:0]      dir_sel_r, dir_sel_nxt;
  logic [ppoc_pkg::POWER_W-1:0]    lvl_r, lvl_nxt;
  logic                            lev_r, lev_nxt;
  logic                            sel2_r, sel2_nxt;
  logic [IDX_W-1:0]                scan_r, scan_nxt;
  logic [PIN_COUNT-1:0]            on_bits_r, on_bits_nxt;
  logic [PIN_COUNT-1:0]            valid_r, valid_nxt;
  logic [ppoc_pkg::MASK_W-1:0]     pwm_mask_r, pwm_mask_nxt;
  logic                            rd_valid_r, rd_valid_nxt;

  logic                            out_valid_r, out_valid_nxt;
  logic [ppoc_pkg::PIN_W-1:0]      out_pin_r, out_pin_nxt;
  logic                            out_dir_r, out_dir_nxt;
  logic                            out_port_r, out_port_nxt;
  logic                            out_pwm_r, out_pwm_nxt;
  logic [ppoc_pkg::POWER_W-1:0]    out_duty_r, out_duty_nxt;
  logic                            out_rd_r, out_rd_nxt;
  logic                            out_an_r, out_an_nxt;
  logic                            out_last_r, out_last_nxt;

  ppoc_pkg::pin_rec_t              mem [PIN_COUNT];
  ppoc_pkg::pin_rec_t              rd_data_r;
  logic                            rd_en;
  logic [IDX_W-1:0]                rd_addr;
  logic                            mem_we;

  logic [IDX_W-1:0]                cur_idx;
  logic [PIN_COUNT-1:0]            pin_bit;
  logic                            pin_ok, sec_ok, cur_analog;
  ppoc_pkg::pin_rec_t              rec, new_rec;
  logic                            new_on, is_upd, capable, last_val;
  logic [ppoc_pkg::POWER_W-1:0]    eff;
  logic [PIN_COUNT-1:0]            on_upd;

  assign in_act     = ppoc_pkg::action_t'(in_action);
  assign cur_idx    = cur_pin_r[IDX_W-1:0];
  assign pin_bit    = PIN_COUNT'(1) << cur_idx;
  assign pin_ok     = {1'b0, in_pin} < CMP_W'(PIN_COUNT);
  assign sec_ok     = {1'b0, in_second_pin} < CMP_W'(PIN_COUNT);
  assign cur_analog = {1'b0, cur_pin_r} >= CMP_W'(ANALOG_FIRST);
  assign capable    = pwm_mask_r[cur_pin_r];

  // record modify
  always_comb begin
    if (rd_valid_r) begin
      rec = rd_data_r;
    end else begin
      rec.power = ppoc_pkg::POWER_MAX;
      rec.pull  = !cur_analog;
      rec.dir   = 1'b0;
      rec.port  = 1'b0;
      rec.pwm   = 1'b0;
    end
    new_rec = rec;
    new_on  = on_bits_r[cur_idx];
    case (act_r) inside
      ppoc_pkg::ACT_SELECT:    new_rec.dir   = 1'b1;
      ppoc_pkg::ACT_SET_POWER: new_rec.power = lvl_r;
      ppoc_pkg::ACT_ON, ppoc_pkg::ACT_LEFT: new_on = 1'b1;
      ppoc_pkg::ACT_OFF, ppoc_pkg::ACT_RIGHT, ppoc_pkg::ACT_STOP_ALL: new_on = 1'b0;
      ppoc_pkg::ACT_PULL_UP:   new_rec.pull  = 1'b1;
      ppoc_pkg::ACT_PULL_NONE: new_rec.pull  = 1'b0;
      ppoc_pkg::ACT_READ: begin
        new_rec.dir  = 1'b0;
        new_rec.port = rec.pull;
      end
      default: ;
    endcase
    eff    = new_on ? new_rec.power : '0;
    is_upd = (act_r == ppoc_pkg::ACT_SET_POWER) || (act_r == ppoc_pkg::ACT_ON) ||
             (act_r == ppoc_pkg::ACT_OFF) || (act_r == ppoc_pkg::ACT_LEFT) ||
             (act_r == ppoc_pkg::ACT_RIGHT) || (act_r == ppoc_pkg::ACT_STOP_ALL);
    if (is_upd) begin
      if (capable && (eff != '0) && (eff != ppoc_pkg::POWER_MAX)) begin
        new_rec.pwm = 1'b1;
      end else begin
        if (capable) begin
          new_rec.pwm = 1'b0;
        end
        new_rec.port = (eff != '0);
      end
    end
    on_upd = (on_bits_r & ~pin_bit) | (new_on ? pin_bit : '0);
    case (act_r)
      ppoc_pkg::ACT_SELECT:   last_val = sel2_r;
      ppoc_pkg::ACT_STOP_ALL: last_val = (on_upd == '0);
      default:                last_val = 1'b1;
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    act_nxt       = act_r;
    cur_pin_nxt   = cur_pin_r;
    sec_nxt       = sec_r;
    power_sel_nxt = power_sel_r;
    dir_sel_nxt   = dir_sel_r;
    lvl_nxt       = lvl_r;
    lev_nxt       = lev_r;
    sel2_nxt      = sel2_r;
    scan_nxt      = scan_r;
    on_bits_nxt   = on_bits_r;
    valid_nxt     = valid_r;
    pwm_mask_nxt  = cfg_valid ? cfg_pwm_capable_mask : pwm_mask_r;
    rd_valid_nxt  = rd_valid_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_pin_nxt   = out_pin_r;
    out_dir_nxt   = out_dir_r;
    out_port_nxt  = out_port_r;
    out_pwm_nxt   = out_pwm_r;
    out_duty_nxt  = out_duty_r;
    out_rd_nxt    = out_rd_r;
    out_an_nxt    = out_an_r;
    out_last_nxt  = out_last_r;
    rd_en         = 1'b0;
    rd_addr       = cur_idx;
    mem_we        = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          act_nxt  = in_act;
          lvl_nxt  = in_power_level;
          lev_nxt  = in_pin_in_level;
          sel2_nxt = 1'b0;
          case (in_act) inside
            ppoc_pkg::ACT_SELECT: begin
              if (pin_ok && sec_ok) begin
                power_sel_nxt = in_pin;
                dir_sel_nxt   = in_second_pin;
                sec_nxt       = in_second_pin;
                cur_pin_nxt   = in_pin;
                rd_en         = 1'b1;
                rd_addr       = in_pin[IDX_W-1:0];
                state_nxt     = S_MOD;
              end
            end
            ppoc_pkg::ACT_SET_POWER, ppoc_pkg::ACT_ON, ppoc_pkg::ACT_OFF: begin
              cur_pin_nxt = power_sel_r;
              rd_en       = 1'b1;
              rd_addr     = power_sel_r[IDX_W-1:0];
              state_nxt   = S_MOD;
            end
            ppoc_pkg::ACT_LEFT, ppoc_pkg::ACT_RIGHT: begin
              cur_pin_nxt = dir_sel_r;
              rd_en       = 1'b1;
              rd_addr     = dir_sel_r[IDX_W-1:0];
              state_nxt   = S_MOD;
            end
            ppoc_pkg::ACT_PULL_UP, ppoc_pkg::ACT_PULL_NONE, ppoc_pkg::ACT_READ: begin
              if (pin_ok) begin
                cur_pin_nxt = in_pin;
                rd_en       = 1'b1;
                rd_addr     = in_pin[IDX_W-1:0];
                state_nxt   = S_MOD;
              end
            end
            ppoc_pkg::ACT_STOP_ALL: begin
              scan_nxt  = '0;
              state_nxt = S_SCAN;
            end
            default: ;
          endcase
        end
      end
      S_ISSUE: begin
        rd_en     = 1'b1;
        state_nxt = S_MOD;
      end
      S_SCAN: begin
        if (on_bits_r == '0) begin
          state_nxt = S_IDLE;
        end else if (on_bits_r[scan_r]) begin
          cur_pin_nxt = ppoc_pkg::PIN_W'(scan_r);
          rd_en       = 1'b1;
          rd_addr     = scan_r;
          scan_nxt    = IDX_W'(scan_r + 1'b1);
          state_nxt   = S_MOD;
        end else begin
          scan_nxt = IDX_W'(scan_r + 1'b1);
        end
      end
      S_MOD: begin
        if (!out_valid_r || out_ready) begin
          mem_we             = 1'b1;
          valid_nxt[cur_idx] = 1'b1;
          on_bits_nxt        = on_upd;
          out_valid_nxt      = 1'b1;
          out_pin_nxt        = cur_pin_r;
          out_dir_nxt        = new_rec.dir;
          out_port_nxt       = new_rec.port;
          out_pwm_nxt        = new_rec.pwm;
          out_duty_nxt       = eff;
          out_rd_nxt         = (act_r == ppoc_pkg::ACT_READ) && !cur_analog && lev_r;
          out_an_nxt         = (act_r == ppoc_pkg::ACT_READ) && cur_analog;
          out_last_nxt       = last_val;
          if (act_r == ppoc_pkg::ACT_SELECT && !sel2_r) begin
            cur_pin_nxt = sec_r;
            sel2_nxt    = 1'b1;
            state_nxt   = S_ISSUE;
          end else if (act_r == ppoc_pkg::ACT_STOP_ALL) begin
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (rd_en) begin
      rd_valid_nxt = valid_nxt[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      act_r       <= ppoc_pkg::ACT_SELECT;
      cur_pin_r   <= '0;
      sec_r       <= '0;
      power_sel_r <= '0;
      dir_sel_r   <= '0;
      lvl_r       <= '0;
      lev_r       <= 1'b0;
      sel2_r      <= 1'b0;
      scan_r      <= '0;
      on_bits_r   <= '0;
      valid_r     <= '0;
      pwm_mask_r  <= ppoc_pkg::PWM_MASK_RESET;
      rd_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      out_pin_r   <= '0;
      out_dir_r   <= 1'b0;
      out_port_r  <= 1'b0;
      out_pwm_r   <= 1'b0;
      out_duty_r  <= '0;
      out_rd_r    <= 1'b0;
      out_an_r    <= 1'b0;
      out_last_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      act_r       <= act_nxt;
      cur_pin_r   <= cur_pin_nxt;
      sec_r       <= sec_nxt;
      power_sel_r <= power_sel_nxt;
      dir_sel_r   <= dir_sel_nxt;
      lvl_r       <= lvl_nxt;
      lev_r       <= lev_nxt;
      sel2_r      <= sel2_nxt;
      scan_r      <= scan_nxt;
      on_bits_r   <= on_bits_nxt;
      valid_r     <= valid_nxt;
      pwm_mask_r  <= pwm_mask_nxt;
      rd_valid_r  <= rd_valid_nxt;
      out_valid_r <= out_valid_nxt;
      out_pin_r   <= out_pin_nxt;
      out_dir_r   <= out_dir_nxt;
      out_port_r  <= out_port_nxt;
      out_pwm_r   <= out_pwm_nxt;
      out_duty_r  <= out_duty_nxt;
      out_rd_r    <= out_rd_nxt;
      out_an_r    <= out_an_nxt;
      out_last_r  <= out_last_nxt;
    end
  end

  // pin record memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[cur_idx] <= new_rec;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign in_ready       = (state_r == S_IDLE);
  assign cfg_ready      = 1'b1;
  assign out_valid      = out_valid_r;
  assign out_pin        = out_pin_r;
  assign out_dir_output = out_dir_r;
  assign out_port_level = out_port_r;
  assign out_pwm_enable = out_pwm_r;
  assign out_duty       = out_duty_r;
  assign out_read_value = out_rd_r;
  assign out_is_analog  = out_an_r;
  assign out_last       = out_last_r;

endmodule

`default_nettype wire

// ----- sim/pin_power_output_controller_unit_tb.sv -----
// Testbench for the pin power output controller: directed and random command transactions.
`timescale 1ns / 100ps

module pin_power_output_controller_unit_tb;

  localparam int CLK_HALF    = 5;
  localparam int CYCLE_LIMIT = 500000;
  localparam int SETTLE      = 300;
  localparam int IDLE_PCT    = 26;
  localparam int HOLD_CYCLES = 400;
  localparam int NUM_PINS    = ppoc_pkg::PIN_COUNT_DEF;
  localparam int PIN_W       = ppoc_pkg::PIN_W;
  localparam int ACT_W       = ppoc_pkg::ACT_W;
  localparam int POWER_W     = ppoc_pkg::POWER_W;
  localparam int MASK_W      = ppoc_pkg::MASK_W;
  localparam int ANALOG_FIRST_DEF = ppoc_pkg::ANALOG_FIRST_DEF;
  localparam logic [POWER_W-1:0] POWER_MAX      = ppoc_pkg::POWER_MAX;
  localparam logic [MASK_W-1:0]  PWM_MASK_RESET = ppoc_pkg::PWM_MASK_RESET;

  typedef struct packed {
    logic [PIN_W-1:0]   pin;
    logic               dir;
    logic               port;
    logic               pwm;
    logic [POWER_W-1:0] duty;
    logic               rd;
    logic               an;
    logic               last;
  } pin_report_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic [ACT_W-1:0]    in_action;
  logic [PIN_W-1:0]    in_pin;
  logic [PIN_W-1:0]    in_second_pin;
  logic [POWER_W-1:0]  in_power_level;
  logic                in_pin_in_level;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [MASK_W-1:0]   cfg_pwm_capable_mask;
  logic                out_valid;
  logic                out_ready;
  logic [PIN_W-1:0]    out_pin;
  logic                out_dir_output;
  logic                out_port_level;
  logic                out_pwm_enable;
  logic [POWER_W-1:0]  out_duty;
  logic                out_read_value;
  logic                out_is_analog;
  logic                out_last;

  pin_report_t pin_reports[$];
  pin_report_t want;
  int          errors = 0;
  bit          calm = 1'b0;
  int          hold_reqs = 0;

  // pin state kept by the predictor
  logic [POWER_W-1:0] m_power[NUM_PINS];
  logic [MASK_W-1:0]  m_on, m_pull, m_dir, m_port, m_pwm, m_cap;
  logic [PIN_W-1:0]   m_pwr_sel, m_dir_sel;

  pin_power_output_controller_unit u_top (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_action            (in_action),
    .in_pin               (in_pin),
    .in_second_pin        (in_second_pin),
    .in_power_level       (in_power_level),
    .in_pin_in_level      (in_pin_in_level),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_pwm_capable_mask (cfg_pwm_capable_mask),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_pin              (out_pin),
    .out_dir_output       (out_dir_output),
    .out_port_level       (out_port_level),
    .out_pwm_enable       (out_pwm_enable),
    .out_duty             (out_duty),
    .out_read_value       (out_read_value),
    .out_is_analog        (out_is_analog),
    .out_last             (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  function automatic void model_reset();
    for (int i = 0; i < NUM_PINS; i++) begin
      m_power[i] = POWER_MAX;
      m_pull[i]  = (i < ANALOG_FIRST_DEF);
    end
    m_on      = '0;
    m_dir     = '0;
    m_port    = '0;
    m_pwm     = '0;
    m_cap     = PWM_MASK_RESET;
    m_pwr_sel = '0;
    m_dir_sel = '0;
  endfunction

  function automatic logic [POWER_W-1:0] drive_level(input logic [PIN_W-1:0] p);
    return m_on[p] ? m_power[p] : '0;
  endfunction

  function automatic void update_drive(input logic [PIN_W-1:0] p);
    logic [POWER_W-1:0] e;
    e = drive_level(p);
    if (m_cap[p]) begin
      if (e != '0 && e != POWER_MAX) begin
        m_pwm[p] = 1'b1;
        return;
      end
      m_pwm[p] = 1'b0;
    end
    m_port[p] = (e != '0);
  endfunction

  function automatic void push_report(input logic [PIN_W-1:0] p, input logic rd,
                                      input logic an);
    pin_report_t r;
    r.pin  = p;
    r.dir  = m_dir[p];
    r.port = m_port[p];
    r.pwm  = m_pwm[p];
    r.duty = drive_level(p);
    r.rd   = rd;
    r.an   = an;
    r.last = 1'b0;
    pin_reports.push_back(r);
  endfunction

  function automatic void apply_command(input logic [ACT_W-1:0] act, input logic [PIN_W-1:0] p,
                                        input logic [PIN_W-1:0] sp,
                                        input logic [POWER_W-1:0] lvl, input logic lev);
    int          n_prior;
    pin_report_t r;
    n_prior = pin_reports.size();
    case (act)
      ppoc_pkg::ACT_SELECT: begin
        m_dir[p]  = 1'b1;
        m_dir[sp] = 1'b1;
        m_pwr_sel = p;
        m_dir_sel = sp;
        push_report(p, 1'b0, 1'b0);
        push_report(sp, 1'b0, 1'b0);
      end
      ppoc_pkg::ACT_SET_POWER, ppoc_pkg::ACT_ON, ppoc_pkg::ACT_OFF: begin
        if (act == ppoc_pkg::ACT_SET_POWER) m_power[m_pwr_sel] = lvl;
        else m_on[m_pwr_sel] = (act == ppoc_pkg::ACT_ON);
        update_drive(m_pwr_sel);
        push_report(m_pwr_sel, 1'b0, 1'b0);
      end
      ppoc_pkg::ACT_LEFT, ppoc_pkg::ACT_RIGHT: begin
        m_on[m_dir_sel] = (act == ppoc_pkg::ACT_LEFT);
        update_drive(m_dir_sel);
        push_report(m_dir_sel, 1'b0, 1'b0);
      end
      ppoc_pkg::ACT_PULL_UP, ppoc_pkg::ACT_PULL_NONE: begin
        m_pull[p] = (act == ppoc_pkg::ACT_PULL_UP);
        push_report(p, 1'b0, 1'b0);
      end
      ppoc_pkg::ACT_READ: begin
        m_dir[p]  = 1'b0;
        m_port[p] = m_pull[p];
        if (int'(p) >= ANALOG_FIRST_DEF) push_report(p, 1'b0, 1'b1);
        else push_report(p, lev, 1'b0);
      end
      ppoc_pkg::ACT_STOP_ALL: begin
        for (int i = 0; i < NUM_PINS; i++) begin
          if (m_on[i]) begin
            m_on[i] = 1'b0;
            update_drive(PIN_W'(i));
            push_report(PIN_W'(i), 1'b0, 1'b0);
          end
        end
      end
      default: ;
    endcase
    if (pin_reports.size() > n_prior) begin
      r = pin_reports.pop_back();
      r.last = 1'b1;
      pin_reports.push_back(r);
    end
  endfunction

  function automatic logic [PIN_W-1:0] rand_pin();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return PIN_W'(ANALOG_FIRST_DEF);
      3: return PIN_W'(ANALOG_FIRST_DEF - 1);
      default: return PIN_W'($urandom);
    endcase
  endfunction

  function automatic logic [POWER_W-1:0] rand_level();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return POWER_W'(1);
      2: return POWER_MAX - 1'b1;
      3: return POWER_MAX;
      default: return POWER_W'($urandom);
    endcase
  endfunction

  // valid stays high across back-to-back transactions; lowered only for a gap
  task automatic send_cmd(input logic [ACT_W-1:0] act, input logic [PIN_W-1:0] p,
                          input logic [PIN_W-1:0] sp, input logic [POWER_W-1:0] lvl,
                          input logic lev);
    if (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_action       <= act;
    in_pin          <= p;
    in_second_pin   <= sp;
    in_power_level  <= lvl;
    in_pin_in_level <= lev;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    apply_command(act, p, sp, lvl, lev);
  endtask

  task automatic send_random_cmd();
    int               r;
    logic [ACT_W-1:0] act;
    r = $urandom_range(0, 99);
    if (r < 12) act = ppoc_pkg::ACT_SELECT;
    else if (r < 30) act = ppoc_pkg::ACT_SET_POWER;
    else if (r < 42) act = ppoc_pkg::ACT_ON;
    else if (r < 50) act = ppoc_pkg::ACT_OFF;
    else if (r < 60) act = ppoc_pkg::ACT_LEFT;
    else if (r < 67) act = ppoc_pkg::ACT_RIGHT;
    else if (r < 73) act = ppoc_pkg::ACT_PULL_UP;
    else if (r < 79) act = ppoc_pkg::ACT_PULL_NONE;
    else if (r < 92) act = ppoc_pkg::ACT_READ;
    else if (r < 96) act = ppoc_pkg::ACT_STOP_ALL;
    else act = ACT_W'($urandom_range(int'(ppoc_pkg::ACT_STOP_ALL) + 1, (1 << ACT_W) - 1));
    send_cmd(act, rand_pin(), rand_pin(), rand_level(), 1'($urandom));
  endtask

  task automatic random_burst(input int count);
    repeat (count) send_random_cmd();
  endtask

  // stop all with nothing on gives no report, so allow for the scan afterwards
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pin_reports.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_mask(input logic [MASK_W-1:0] mask);
    wait_drained();
    cfg_valid            <= 1'b1;
    cfg_pwm_capable_mask <= mask;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    m_cap = mask;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_reset_state();
    send_cmd(ppoc_pkg::ACT_READ, 6'd0, 6'd0, 8'd0, 1'b1);
    send_cmd(ppoc_pkg::ACT_READ, '1, 6'd0, 8'd0, 1'b1);
    send_cmd(ppoc_pkg::ACT_READ, PIN_W'(ANALOG_FIRST_DEF - 1), 6'd0, 8'd0, 1'b0);
    send_cmd(ppoc_pkg::ACT_READ, PIN_W'(ANALOG_FIRST_DEF), 6'd0, 8'd0, 1'b1);
  endtask

  task automatic test_power_pin_drive();
    send_cmd(ppoc_pkg::ACT_SELECT, 6'd2, 6'd2, 8'd0, 1'b0);
    send_cmd(ppoc_pkg::ACT_SET_POWER, 6'd0, 6'd0, 8'd128, 1'b0);
    send_cmd(ppoc_pkg::ACT_ON, 6'd0, 6'd0, 8'd0, 1'b0);
    send_cmd(ppoc_pkg::ACT_SET_POWER, 6'd0, 6'd0, POWER_MAX, 1'b0);
    send_cmd(ppoc_pkg::ACT_SET_POWER, 6'd0, 6'd0, 8'd0, 1'b0);
    send_cmd(ppoc_pkg::ACT_SET_POWER, 6'd0, 6'd0, 8'd1, 1'b0);
    send_cmd(ppoc_pkg::ACT_OFF, 6'd0, 6'd0, 8'd0, 1'b0);
    send_cmd(ppoc_pkg::ACT_SELECT, 6'd0, '1, 8'd0, 1'b0);
    send_cmd(ppoc_pkg::ACT_LEFT, 6'd0, 6'd0, 8'd0, 1'b0);
    send_cmd(ppoc_pkg::ACT_RIGHT, 6'd0, 6'd0, 8'd0, 1'b0);
    send_cmd(ppoc_pkg::ACT_SET_POWER, 6'd0, 6'd0, POWER_MAX - 1'b1, 1'b0);
    send_cmd(ppoc_pkg::ACT_ON, 6'd0, 6'd0, 8'd0, 1'b0);
  endtask

  task automatic test_pull_and_read();
    send_cmd(ppoc_pkg::ACT_PULL_NONE, 6'd5, 6'd0, 8'd0, 1'b0);
    send_cmd(ppoc_pkg::ACT_READ, 6'd5, 6'd0, 8'd0, 1'b1);
    send_cmd(ppoc_pkg::ACT_PULL_UP, '1, 6'd0, 8'd0, 1'b0);
    send_cmd(ppoc_pkg::ACT_READ, '1, 6'd0, 8'd0, 1'b1);
  endtask

  task automatic test_ignored_actions();
    send_cmd(ACT_W'(int'(ppoc_pkg::ACT_STOP_ALL) + 1), 6'd0, 6'd0, 8'd0, 1'b0);
    send_cmd('1, '1, '1, '1, 1'b1);
    send_cmd(ppoc_pkg::ACT_STOP_ALL, 6'd0, 6'd0, 8'd0, 1'b0);
    send_cmd(ppoc_pkg::ACT_STOP_ALL, 6'd0, 6'd0, 8'd0, 1'b0);
  endtask

  // every pin on, then one stop all; the receiver holds off from the start of the sequence
  task automatic test_stop_all_backpressure();
    hold_reqs++;
    for (int i = 0; i < NUM_PINS; i++) begin
      send_cmd(ppoc_pkg::ACT_SELECT, PIN_W'(i), PIN_W'(NUM_PINS - 1 - i), rand_level(),
               1'($urandom));
      send_cmd(ppoc_pkg::ACT_ON, rand_pin(), rand_pin(), rand_level(), 1'($urandom));
    end
    send_cmd(ppoc_pkg::ACT_STOP_ALL, rand_pin(), rand_pin(), rand_level(), 1'($urandom));
  endtask

  task automatic test_mask_settings();
    write_mask('1);
    random_burst(60);
    write_mask('0);
    random_burst(60);
    write_mask({$urandom, $urandom});
    random_burst(40);
  endtask

  task automatic test_calm_stream();
    calm = 1'b1;
    random_burst(40);
    calm = 1'b0;
  endtask

  task automatic test_drain_pause();
    random_burst(15);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pin_reports.size() != 0) @(posedge clk);
    random_burst(15);
    write_mask(PWM_MASK_RESET);
    random_burst(20);
  endtask

  initial begin
    rst_n                <= 1'b0;
    in_valid             <= 1'b0;
    in_action            <= '0;
    in_pin               <= '0;
    in_second_pin        <= '0;
    in_power_level       <= '0;
    in_pin_in_level      <= 1'b0;
    cfg_valid            <= 1'b0;
    cfg_pwm_capable_mask <= '0;
    model_reset();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_state();
    test_power_pin_drive();
    test_pull_and_read();
    test_ignored_actions();
    test_stop_all_backpressure();
    test_mask_settings();
    test_calm_stream();
    test_drain_pause();
    wait_drained();
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  // receiver: random stalls, calm stretches and requested long hold-offs
  initial begin
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_seen != hold_reqs) begin
        hold_seen = hold_reqs;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (calm) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  function automatic void check_field(input string name, input logic [7:0] exp_val,
                                      input logic [7:0] got);
    if (got !== exp_val) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_val, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pin_reports.size() == 0) begin
        $error("unexpected transaction for pin %0d", out_pin);
        errors++;
      end else begin
        want = pin_reports.pop_front();
        check_field("out_pin", 8'(want.pin), 8'(out_pin));
        check_field("dir_output", 8'(want.dir), 8'(out_dir_output));
        check_field("port_level", 8'(want.port), 8'(out_port_level));
        check_field("pwm_enable", 8'(want.pwm), 8'(out_pwm_enable));
        check_field("duty", want.duty, out_duty);
        check_field("read_value", 8'(want.rd), 8'(out_read_value));
        check_field("is_analog", 8'(want.an), 8'(out_is_analog));
        check_field("last", 8'(want.last), 8'(out_last));
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("TEST FAILED");
    $finish;
  end

endmodule
